### hw/rtl/lbh_pkg.sv
// ----------------------------------------------------------------------------
// lbh_pkg: shared definitions for the lookup2 byte stream hash
// Word widths, mixing constants and the command passed from the byte front
// end to the mixing back end.
// ----------------------------------------------------------------------------
package lbh_pkg;

   localparam int WORD_W       = 32;
   localparam int BYTE_W       = 8;
   localparam int BLOCK_LEN    = 12;
   localparam int FILL_W       = 4;
   localparam int STEP_W       = 4;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [WORD_W-1:0] GOLDEN_RATIO  = 32'h9e3779b9;
   localparam logic [STEP_W-1:0] MIX_LAST_STEP = 4'd8;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] seed;
      logic              block;
      logic              finish;
      logic [WORD_W-1:0] word0;
      logic [WORD_W-1:0] word1;
      logic [WORD_W-1:0] word2;
      logic [WORD_W-1:0] length;
   } lbh_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } lbh_queue_status_type;

   typedef struct packed {
      logic mixing;
   } lbh_back_status_type;

   typedef enum logic {
      BK_IDLE,
      BK_MIX
   } lbh_back_state_type;

endpackage

### hw/rtl/lbh_if.sv
// ----------------------------------------------------------------------------
// lbh_if: handshake channels of the lookup2 byte stream hash
// Key byte channel and hash result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface lbh_req_if;
   import lbh_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              byte_valid;
   logic              first_byte;
   logic [WORD_W-1:0] seed;
   logic              last_byte;

   modport source (output valid, data_byte, byte_valid, first_byte, seed, last_byte,
                   input ready);
   modport sink   (input valid, data_byte, byte_valid, first_byte, seed, last_byte,
                   output ready);
endinterface

interface lbh_rsp_if;
   import lbh_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] digest;

   modport source (output valid, digest, input ready);
   modport sink   (input valid, digest, output ready);
endinterface

### hw/rtl/lbh_front.sv
// ----------------------------------------------------------------------------
// lbh_front: byte collection front end
// Takes key bytes, gathers twelve-byte blocks, tracks the key length and
// issues start, block and finish commands to the mixing back end.
// ----------------------------------------------------------------------------
module lbh_front (
   input  logic                        clock,
   input  logic                        reset,
   lbh_req_if.sink                     req_chan,
   input  lbh_pkg::lbh_queue_status_type q_status,
   output logic                        push,
   output lbh_pkg::lbh_cmd_type        cmd_out
);
   import lbh_pkg::*;

   logic [BYTE_W-1:0] blk_ff [BLOCK_LEN];
   logic [BYTE_W-1:0] blk_in [BLOCK_LEN];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [WORD_W-1:0] len_ff, len_in;

   logic              take;
   logic [FILL_W-1:0] fill_start, fill_byte, fill_tail;
   logic [WORD_W-1:0] len_start, len_byte;
   logic              full;
   logic [BYTE_W-1:0] tail [BLOCK_LEN];
   logic [WORD_W-1:0] blk_w0, blk_w1, blk_w2;
   logic [WORD_W-1:0] tail_w0, tail_w1, tail_w2;

   assign req_chan.ready = !q_status.full;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      fill_start = req_chan.first_byte ? '0 : fill_ff;
      len_start  = req_chan.first_byte ? '0 : len_ff;
      fill_byte  = req_chan.byte_valid ? fill_start + FILL_W'(1) : fill_start;
      len_byte   = req_chan.byte_valid ? len_start + WORD_W'(1) : len_start;
      full       = req_chan.byte_valid && (fill_byte == FILL_W'(BLOCK_LEN));
      fill_tail  = full ? '0 : fill_byte;

      for (int i = 0; i < BLOCK_LEN; i++) begin
         if (req_chan.byte_valid && (fill_start == FILL_W'(i))) begin
            blk_in[i] = req_chan.data_byte;
         end else begin
            blk_in[i] = blk_ff[i];
         end
         tail[i] = (FILL_W'(i) < fill_tail) ? blk_in[i] : '0;
      end

      blk_w0  = {blk_in[3], blk_in[2], blk_in[1], blk_in[0]};
      blk_w1  = {blk_in[7], blk_in[6], blk_in[5], blk_in[4]};
      blk_w2  = {blk_in[11], blk_in[10], blk_in[9], blk_in[8]};
      tail_w0 = {tail[3], tail[2], tail[1], tail[0]};
      tail_w1 = {tail[7], tail[6], tail[5], tail[4]};
      tail_w2 = {tail[10], tail[9], tail[8], {BYTE_W{1'b0}}};

      fill_in = req_chan.last_byte ? '0 : fill_tail;
      len_in  = req_chan.last_byte ? '0 : len_byte;

      push           = take && (req_chan.first_byte || full || req_chan.last_byte);
      cmd_out.start  = req_chan.first_byte;
      cmd_out.seed   = req_chan.seed;
      cmd_out.block  = full;
      cmd_out.finish = req_chan.last_byte;
      cmd_out.word0  = full ? blk_w0 : tail_w0;
      cmd_out.word1  = full ? blk_w1 : tail_w1;
      cmd_out.word2  = full ? blk_w2 : tail_w2;
      cmd_out.length = len_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
      end else if (take) begin
         fill_ff <= fill_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         blk_ff <= blk_in;
      end
   end

endmodule

### hw/rtl/lbh_queue.sv
// ----------------------------------------------------------------------------
// lbh_queue: command queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module lbh_queue #(
   parameter int DEPTH = lbh_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  lbh_pkg::lbh_cmd_type         push_cmd,
   input  logic                         pop,
   output lbh_pkg::lbh_cmd_type         pop_cmd,
   output lbh_pkg::lbh_queue_status_type status
);
   import lbh_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lbh_cmd_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == CNT_W'(DEPTH));
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      pop_cmd      = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/lbh_back.sv
// ----------------------------------------------------------------------------
// lbh_back: mixing back end
// Holds the three hash words, applies commands and runs the mix one step a
// cycle, a finish's last step held while a hash waits in the output register.
// ----------------------------------------------------------------------------
module lbh_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lbh_pkg::lbh_queue_status_type q_status,
   input  lbh_pkg::lbh_cmd_type          cmd_in,
   output logic                          pop,
   lbh_rsp_if.source                     rsp_chan,
   output lbh_pkg::lbh_back_status_type  status
);
   import lbh_pkg::*;

   lbh_back_state_type state_ff, state_in;
   logic [WORD_W-1:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               finish_ff, finish_in;
   logic               second_ff, second_in;
   logic [WORD_W-1:0]  len_ff, len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  hash_ff, hash_in;

   logic [WORD_W-1:0]  x, y, z, sh, mixv;
   logic [WORD_W-1:0]  base_a, base_b, base_c;
   logic [1:0]         role;
   logic               out_free;

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.digest = hash_ff;
   assign status.mixing   = (state_ff == BK_MIX);

   always_comb begin
      case (step_ff)
         4'd0, 4'd3, 4'd6: role = 2'd0;
         4'd1, 4'd4, 4'd7: role = 2'd1;
         default:          role = 2'd2;
      endcase
      case (role)
         2'd0: begin
            x = a_ff; y = b_ff; z = c_ff;
         end
         2'd1: begin
            x = b_ff; y = c_ff; z = a_ff;
         end
         default: begin
            x = c_ff; y = a_ff; z = b_ff;
         end
      endcase
      case (step_ff)
         4'd0:    sh = z >> 13;
         4'd1:    sh = z << 8;
         4'd2:    sh = z >> 13;
         4'd3:    sh = z >> 12;
         4'd4:    sh = z << 16;
         4'd5:    sh = z >> 5;
         4'd6:    sh = z >> 3;
         4'd7:    sh = z << 10;
         default: sh = z >> 15;
      endcase
      mixv = (x - y - z) ^ sh;

      base_a = cmd_in.start ? GOLDEN_RATIO : a_ff;
      base_b = cmd_in.start ? GOLDEN_RATIO : b_ff;
      base_c = cmd_in.start ? cmd_in.seed : c_ff;

      out_free = !rsp_valid_ff || rsp_chan.ready;

      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      step_in      = step_ff;
      finish_in    = finish_ff;
      second_in    = second_ff;
      len_in       = len_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pop          = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop     = 1'b1;
               step_in = '0;
               len_in  = cmd_in.length;
               if (cmd_in.block) begin
                  a_in      = base_a + cmd_in.word0;
                  b_in      = base_b + cmd_in.word1;
                  c_in      = base_c + cmd_in.word2;
                  finish_in = 1'b0;
                  second_in = cmd_in.finish;
                  state_in  = BK_MIX;
               end else if (cmd_in.finish) begin
                  a_in      = base_a + cmd_in.word0;
                  b_in      = base_b + cmd_in.word1;
                  c_in      = base_c + cmd_in.word2 + cmd_in.length;
                  finish_in = 1'b1;
                  second_in = 1'b0;
                  state_in  = BK_MIX;
               end else begin
                  a_in = base_a;
                  b_in = base_b;
                  c_in = base_c;
               end
            end
         end
         BK_MIX: begin
            if (step_ff != MIX_LAST_STEP) begin
               case (role)
                  2'd0:    a_in = mixv;
                  2'd1:    b_in = mixv;
                  default: c_in = mixv;
               endcase
               step_in = step_ff + STEP_W'(1);
            end else if (!finish_ff || out_free) begin
               step_in = '0;
               if (second_ff) begin
                  c_in      = mixv + len_ff;
                  finish_in = 1'b1;
                  second_in = 1'b0;
               end else begin
                  c_in     = mixv;
                  state_in = BK_IDLE;
                  if (finish_ff) begin
                     hash_in      = mixv;
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         a_ff         <= '0;
         b_ff         <= '0;
         c_ff         <= '0;
         step_ff      <= '0;
         finish_ff    <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         step_ff      <= step_in;
         finish_ff    <= finish_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      hash_ff <= hash_in;
   end

endmodule

### hw/rtl/lookup2_byte_stream_hash.sv
// Throughput: one byte transfer per cycle while the command queue is not full;
// the nine-step mixer takes a command only when idle, the queue absorbing the difference.
// Reset clears the hash words, block fill, key length, queue and result valid flag.
// ----------------------------------------------------------------------------
// lookup2_byte_stream_hash: 32-bit lookup2 hash over a byte stream
// A front end gathers key bytes into blocks, a queue carries commands, and a
// back end mixes the hash words and delivers the result.
// ----------------------------------------------------------------------------
module lookup2_byte_stream_hash #(
   parameter int QUEUE_DEPTH = lbh_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   lbh_req_if.sink   req_chan,
   lbh_rsp_if.source rsp_chan
);
   import lbh_pkg::*;

   lbh_queue_status_type q_status;
   lbh_back_status_type  back_status;
   lbh_cmd_type          push_cmd, pop_cmd;
   logic                 push, pop;

   lbh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .cmd_out  (push_cmd)
   );

   lbh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   lbh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .cmd_in   (pop_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan),
      .status   (back_status)
   );

   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_byte) |=> !q_status.empty)
      else $error("final transfer left no command in the queue");

   a_result_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(back_status.mixing))
      else $error("result appeared without a mix");

   a_no_pop_while_mixing: assert property (@(posedge clock) disable iff (reset)
      back_status.mixing |-> !pop)
      else $error("command taken while the mixer was busy");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("queue reported empty and full together");

endmodule
